// ===== hdl/rdcw_pkg.sv =====
// Shared constants, types and helpers for the range distinct count block.
// Used by rdcw_tables, rdcw_ctrl and range_distinct_count_window.
package rdcw_pkg;

    localparam int MAX_LENGTH  = 1024;
    localparam int VALUE_RANGE = 1024;

    localparam int POS_W = $clog2(MAX_LENGTH);
    localparam int VAL_W = $clog2(VALUE_RANGE);
    localparam int CNT_W = $clog2(MAX_LENGTH + 1);
    localparam int LEN_W = 11;
    localparam int TAG_W = 16;
    localparam int IN_W  = 10;

    localparam logic [LEN_W-1:0] MAX_LEN_L  = LEN_W'(MAX_LENGTH);
    localparam logic [LEN_W-1:0] LEN_RESET  = LEN_W'(1024);
    localparam logic [VAL_W-1:0] LAST_VALUE = VAL_W'(VALUE_RANGE - 1);

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    typedef enum logic [1:0] {
        T_IDLE,
        T_CNT,
        T_UPD,
        T_CLEAR
    } tbl_state_t;

    typedef enum logic [2:0] {
        C_BOOT,
        C_CLEARING,
        C_IDLE,
        C_STEP,
        C_STEP_WAIT,
        C_FINISH
    } ctl_state_t;

    // commands from the sequencer to the table unit
    typedef struct packed {
        logic             step_go;
        logic             step_add;
        logic [POS_W-1:0] step_pos;
        logic             clear_go;
        logic             load_we;
        logic [POS_W-1:0] load_pos;
        logic [VAL_W-1:0] load_val;
    } tbl_cmd_t;

    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] distinct;
    } tbl_stat_t;

    function automatic logic [VAL_W-1:0] sat_value(input logic [IN_W-1:0] v);
        if (32'(v) >= VALUE_RANGE)
            return LAST_VALUE;
        return VAL_W'(v);
    endfunction

endpackage

// ===== hdl/rdcw_tables.sv =====
// Element store, occurrence count table and the shared count update unit.
// One add or remove is a read-modify-write through states T_CNT and T_UPD; clear sweeps the table.
// Depends on rdcw_pkg.
module rdcw_tables (
    input  logic              clk,
    input  logic              rst_n,
    input  rdcw_pkg::tbl_cmd_t  cmd,
    output rdcw_pkg::tbl_stat_t stat
);

    logic [rdcw_pkg::VAL_W-1:0] element_store [rdcw_pkg::MAX_LENGTH];
    logic [rdcw_pkg::CNT_W-1:0] occurrence_table [rdcw_pkg::VALUE_RANGE];

    rdcw_pkg::tbl_state_t state_reg, state_next;

    logic                       add_reg, add_next;
    logic [rdcw_pkg::VAL_W-1:0] vaddr_reg, vaddr_next;
    logic [rdcw_pkg::VAL_W-1:0] clr_addr_reg, clr_addr_next;
    logic [rdcw_pkg::CNT_W-1:0] distinct_reg, distinct_next;

    logic [rdcw_pkg::VAL_W-1:0] elem_q;
    logic [rdcw_pkg::CNT_W-1:0] cnt_q;

    logic                       occ_we;
    logic [rdcw_pkg::VAL_W-1:0] occ_waddr;
    logic [rdcw_pkg::CNT_W-1:0] occ_wdata;

    logic                       cnt_zero;
    logic                       cnt_one;
    logic [rdcw_pkg::CNT_W-1:0] cnt_upd;
    logic                       clr_last;

    always_ff @(posedge clk)
    begin
        if (cmd.load_we)
            element_store[cmd.load_pos] <= cmd.load_val;
        elem_q <= element_store[cmd.step_pos];
    end

    always_ff @(posedge clk)
    begin
        if (occ_we)
            occurrence_table[occ_waddr] <= occ_wdata;
        cnt_q <= occurrence_table[elem_q];
    end

    // shared +/-1 unit on the count word
    assign cnt_zero = (cnt_q == '0);
    assign cnt_one  = (cnt_q == rdcw_pkg::CNT_W'(1));
    always_comb
    begin
        if (add_reg)
            cnt_upd = cnt_q + rdcw_pkg::CNT_W'(1);
        else if (cnt_zero)
            cnt_upd = cnt_q;
        else
            cnt_upd = cnt_q - rdcw_pkg::CNT_W'(1);
    end

    assign clr_last = (clr_addr_reg == rdcw_pkg::LAST_VALUE);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rdcw_pkg::T_IDLE:
            begin
                if (cmd.clear_go)
                    state_next = rdcw_pkg::T_CLEAR;
                else if (cmd.step_go)
                    state_next = rdcw_pkg::T_CNT;
            end
            rdcw_pkg::T_CNT:   state_next = rdcw_pkg::T_UPD;
            rdcw_pkg::T_UPD:   state_next = rdcw_pkg::T_IDLE;
            rdcw_pkg::T_CLEAR:
            begin
                if (clr_last)
                    state_next = rdcw_pkg::T_IDLE;
            end
            default: state_next = rdcw_pkg::T_IDLE;
        endcase
    end

    always_comb
    begin
        occ_we        = 1'b0;
        occ_waddr     = vaddr_reg;
        occ_wdata     = cnt_upd;
        stat.done     = 1'b0;
        stat.distinct = distinct_reg;
        case (state_reg)
            rdcw_pkg::T_UPD:
            begin
                occ_we    = 1'b1;
                stat.done = 1'b1;
            end
            rdcw_pkg::T_CLEAR:
            begin
                occ_we    = 1'b1;
                occ_waddr = clr_addr_reg;
                occ_wdata = '0;
                stat.done = clr_last;
            end
            default:
            begin
                occ_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        add_next      = add_reg;
        vaddr_next    = vaddr_reg;
        clr_addr_next = clr_addr_reg;
        distinct_next = distinct_reg;
        case (state_reg)
            rdcw_pkg::T_IDLE:
            begin
                add_next      = cmd.step_add;
                clr_addr_next = '0;
                if (cmd.clear_go)
                    distinct_next = '0;
            end
            rdcw_pkg::T_CNT:
            begin
                vaddr_next = elem_q;
            end
            rdcw_pkg::T_UPD:
            begin
                if (add_reg && cnt_zero)
                    distinct_next = distinct_reg + rdcw_pkg::CNT_W'(1);
                else if (!add_reg && cnt_one)
                    distinct_next = distinct_reg - rdcw_pkg::CNT_W'(1);
            end
            rdcw_pkg::T_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + rdcw_pkg::VAL_W'(1);
            end
            default:
            begin
                distinct_next = distinct_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= rdcw_pkg::T_IDLE;
            distinct_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            distinct_reg <= distinct_next;
        end
    end

    always_ff @(posedge clk)
    begin
        add_reg      <= add_next;
        vaddr_reg    <= vaddr_next;
        clr_addr_reg <= clr_addr_next;
    end

`ifndef SYNTHESIS
    a_cmd_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step_go || cmd.clear_go) |-> (state_reg == rdcw_pkg::T_IDLE))
        else $error("table unit got a command while busy");

    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rdcw_pkg::T_CLEAR) |-> (distinct_reg == '0))
        else $error("distinct total not zero during clear sweep");
`endif

endmodule

// ===== hdl/rdcw_ctrl.sv =====
// Item sequencer: handshakes, length register, window bounds and the output word.
// Drives rdcw_tables one window move at a time. Depends on rdcw_pkg.
module rdcw_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       opcode,
    input  logic [rdcw_pkg::IN_W-1:0]  position,
    input  logic [rdcw_pkg::IN_W-1:0]  element_value,
    input  logic [rdcw_pkg::IN_W-1:0]  left_end,
    input  logic [rdcw_pkg::IN_W-1:0]  right_end,
    input  logic [rdcw_pkg::TAG_W-1:0] query_tag,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [rdcw_pkg::TAG_W-1:0] answer_tag,
    output logic [rdcw_pkg::CNT_W-1:0] distinct_values,
    output logic                       status,
    input  logic                       cfg_write_en,
    input  logic [rdcw_pkg::LEN_W-1:0] cfg_write_data,
    output rdcw_pkg::tbl_cmd_t         cmd,
    input  rdcw_pkg::tbl_stat_t        stat
);

    rdcw_pkg::ctl_state_t state_reg, state_next;

    logic [rdcw_pkg::LEN_W-1:0] len_reg;
    logic [rdcw_pkg::POS_W-1:0] left_reg, left_next;
    logic [rdcw_pkg::POS_W-1:0] right_reg, right_next;
    logic [rdcw_pkg::TAG_W-1:0] tag_reg, tag_next;
    logic                       bad_reg, bad_next;
    logic [rdcw_pkg::POS_W-1:0] low_reg, low_next;
    logic [rdcw_pkg::POS_W-1:0] high_reg, high_next;
    logic                       empty_reg, empty_next;

    logic                       out_valid_reg, out_valid_next;
    logic [rdcw_pkg::TAG_W-1:0] out_tag_reg, out_tag_next;
    logic [rdcw_pkg::CNT_W-1:0] out_distinct_reg, out_distinct_next;
    logic                       out_status_reg, out_status_next;

    logic                       accept;
    logic                       is_load;
    logic                       range_bad;
    logic [rdcw_pkg::LEN_W-1:0] len_eff;
    logic                       out_free;

    logic                       mv_go;
    logic                       mv_add;
    logic [rdcw_pkg::POS_W-1:0] mv_pos;
    logic [rdcw_pkg::POS_W-1:0] mv_low;
    logic [rdcw_pkg::POS_W-1:0] mv_high;

    assign accept   = in_valid && in_ready;
    assign is_load  = (opcode == rdcw_pkg::OP_LOAD);
    assign out_free = !out_valid_reg || out_ready;
    assign len_eff  = (len_reg > rdcw_pkg::MAX_LEN_L) ? rdcw_pkg::MAX_LEN_L : len_reg;
    assign range_bad = (left_end > right_end) ||
                       ({1'b0, right_end} >= len_eff);

    // next window move: seed an empty window at left, else grow right, grow left, shrink right, shrink left
    always_comb
    begin
        mv_go   = 1'b1;
        mv_add  = 1'b1;
        mv_pos  = high_reg;
        mv_low  = low_reg;
        mv_high = high_reg;
        if (empty_reg)
        begin
            mv_pos  = left_reg;
            mv_low  = left_reg;
            mv_high = left_reg;
        end
        else if (high_reg < right_reg)
        begin
            mv_pos  = high_reg + rdcw_pkg::POS_W'(1);
            mv_high = mv_pos;
        end
        else if (left_reg < low_reg)
        begin
            mv_pos = low_reg - rdcw_pkg::POS_W'(1);
            mv_low = mv_pos;
        end
        else if (high_reg > right_reg)
        begin
            mv_add  = 1'b0;
            mv_pos  = high_reg;
            mv_high = high_reg - rdcw_pkg::POS_W'(1);
        end
        else if (left_reg > low_reg)
        begin
            mv_add = 1'b0;
            mv_pos = low_reg;
            mv_low = low_reg + rdcw_pkg::POS_W'(1);
        end
        else
        begin
            mv_go = 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rdcw_pkg::C_BOOT: state_next = rdcw_pkg::C_CLEARING;
            rdcw_pkg::C_CLEARING:
            begin
                if (stat.done)
                    state_next = rdcw_pkg::C_IDLE;
            end
            rdcw_pkg::C_IDLE:
            begin
                if (in_valid)
                begin
                    if (is_load)
                    begin
                        if (!empty_reg)
                            state_next = rdcw_pkg::C_CLEARING;
                    end
                    else if (range_bad)
                        state_next = rdcw_pkg::C_FINISH;
                    else
                        state_next = rdcw_pkg::C_STEP;
                end
            end
            rdcw_pkg::C_STEP:
                state_next = mv_go ? rdcw_pkg::C_STEP_WAIT : rdcw_pkg::C_FINISH;
            rdcw_pkg::C_STEP_WAIT:
            begin
                if (stat.done)
                    state_next = rdcw_pkg::C_STEP;
            end
            rdcw_pkg::C_FINISH:
            begin
                if (out_free)
                    state_next = rdcw_pkg::C_IDLE;
            end
            default: state_next = rdcw_pkg::C_BOOT;
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        cmd.step_go  = 1'b0;
        cmd.step_add = mv_add;
        cmd.step_pos = mv_pos;
        cmd.clear_go = 1'b0;
        cmd.load_we  = 1'b0;
        cmd.load_pos = position;
        cmd.load_val = rdcw_pkg::sat_value(element_value);
        case (state_reg)
            rdcw_pkg::C_BOOT:
                cmd.clear_go = 1'b1;
            rdcw_pkg::C_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.load_we  = in_valid && is_load;
                cmd.clear_go = in_valid && is_load && !empty_reg;
            end
            rdcw_pkg::C_STEP:
                cmd.step_go = mv_go;
            default:
                in_ready = 1'b0;
        endcase
    end

    always_comb
    begin
        left_next         = left_reg;
        right_next        = right_reg;
        tag_next          = tag_reg;
        bad_next          = bad_reg;
        low_next          = low_reg;
        high_next         = high_reg;
        empty_next        = empty_reg;
        out_valid_next    = out_valid_reg;
        out_tag_next      = out_tag_reg;
        out_distinct_next = out_distinct_reg;
        out_status_next   = out_status_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        if (accept)
        begin
            if (is_load)
            begin
                empty_next = 1'b1;
                low_next   = '0;
                high_next  = '0;
            end
            else
            begin
                left_next  = left_end;
                right_next = right_end;
                tag_next   = query_tag;
                bad_next   = range_bad;
            end
        end

        if (state_reg == rdcw_pkg::C_STEP && mv_go)
        begin
            low_next   = mv_low;
            high_next  = mv_high;
            empty_next = 1'b0;
        end

        if (state_reg == rdcw_pkg::C_FINISH && out_free)
        begin
            out_valid_next    = 1'b1;
            out_tag_next      = tag_reg;
            out_distinct_next = bad_reg ? '0 : stat.distinct;
            out_status_next   = bad_reg ? rdcw_pkg::STATUS_BAD : rdcw_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rdcw_pkg::C_BOOT;
            len_reg       <= rdcw_pkg::LEN_RESET;
            low_reg       <= '0;
            high_reg      <= '0;
            empty_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_write_en)
                len_reg <= cfg_write_data;
            low_reg       <= low_next;
            high_reg      <= high_next;
            empty_reg     <= empty_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg         <= left_next;
        right_reg        <= right_next;
        tag_reg          <= tag_next;
        bad_reg          <= bad_next;
        out_tag_reg      <= out_tag_next;
        out_distinct_reg <= out_distinct_next;
        out_status_reg   <= out_status_next;
    end

    assign out_valid       = out_valid_reg;
    assign answer_tag      = out_tag_reg;
    assign distinct_values = out_distinct_reg;
    assign status          = out_status_reg;

`ifndef SYNTHESIS
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rdcw_pkg::C_IDLE && empty_reg) |-> (stat.distinct == '0))
        else $error("empty window with nonzero distinct total");

    a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == rdcw_pkg::C_FINISH))
        else $error("answer word raised outside finish");

    a_window_order: assert property (@(posedge clk) disable iff (!rst_n)
        !empty_reg |-> (low_reg <= high_reg))
        else $error("window low above window high");
`endif

endmodule

// ===== hdl/range_distinct_count_window.sv =====
// Range distinct count over a loaded array, kept as a sliding window.
// Top level; instantiates rdcw_ctrl and rdcw_tables, depends on rdcw_pkg.
//
// After reset the block sweeps the 1024-entry occurrence table to zero
// with in_ready low (configuration writes still land). A load writes the
// element store; when a window is held it also sweeps the table. A query
// adds or removes window positions one by one; each move is one
// read-modify-write of the occurrence table through one shared +/-1 count
// unit, after a registered read of the element store. A query that starts
// from an empty window walks every position of its range; later queries
// walk only the difference between the old and new ranges. An out-of-range
// query is answered with status 1. Answers leave through an output
// register in arrival order.
module range_distinct_count_window (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       opcode,
    input  logic [rdcw_pkg::IN_W-1:0]  position,
    input  logic [rdcw_pkg::IN_W-1:0]  element_value,
    input  logic [rdcw_pkg::IN_W-1:0]  left_end,
    input  logic [rdcw_pkg::IN_W-1:0]  right_end,
    input  logic [rdcw_pkg::TAG_W-1:0] query_tag,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [rdcw_pkg::TAG_W-1:0] answer_tag,
    output logic [rdcw_pkg::CNT_W-1:0] distinct_values,
    output logic                       status,
    input  logic                       cfg_write_en,
    input  logic [rdcw_pkg::LEN_W-1:0] cfg_write_data
);

    rdcw_pkg::tbl_cmd_t  tbl_cmd;
    rdcw_pkg::tbl_stat_t tbl_stat;

    rdcw_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .opcode          (opcode),
        .position        (position),
        .element_value   (element_value),
        .left_end        (left_end),
        .right_end       (right_end),
        .query_tag       (query_tag),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .answer_tag      (answer_tag),
        .distinct_values (distinct_values),
        .status          (status),
        .cfg_write_en    (cfg_write_en),
        .cfg_write_data  (cfg_write_data),
        .cmd             (tbl_cmd),
        .stat            (tbl_stat)
    );

    rdcw_tables u_tables (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (tbl_cmd),
        .stat  (tbl_stat)
    );

endmodule
